// ----- hdl/mcfc_pkg.sv -----
// Package: shared types, codes and arithmetic helpers of the frustum coverage unit.
package mcfc_pkg;

   // Input function codes
   localparam logic [1:0] FUNC_LOAD_MV = 2'd0;
   localparam logic [1:0] FUNC_LOAD_PJ = 2'd1;
   localparam logic [1:0] FUNC_BUILD   = 2'd2;
   localparam logic [1:0] FUNC_TEST    = 2'd3;

   // Internal command codes after classification
   localparam logic [2:0] OP_NOP     = 3'd0;
   localparam logic [2:0] OP_LOAD_MV = 3'd1;
   localparam logic [2:0] OP_LOAD_PJ = 3'd2;
   localparam logic [2:0] OP_BUILD   = 3'd3;
   localparam logic [2:0] OP_TEST    = 3'd4;

   // Register indexes
   localparam logic CSR_CAMERAS   = 1'b0;
   localparam logic CSR_THRESHOLD = 1'b1;

   localparam logic [3:0] THRESHOLD_RESET = 4'd3;
   localparam int         QUEUE_DEPTH     = 2;
   localparam int         MAX_CAMERAS     = 8;

   localparam logic signed [47:0] PLANE_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] PLANE_MIN = 48'sh8000_0000_0000;

   typedef struct packed {
      logic [1:0]         func;
      logic [2:0]         cam_index;
      logic [1:0]         row_index;
      logic signed [31:0] elem_a;
      logic signed [31:0] elem_b;
      logic signed [31:0] elem_c;
      logic signed [31:0] elem_d;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic [7:0] inside_mask;
      logic [3:0] cover_count;
      logic       covered;
   } rsp_type;

   // Classified command between front and back
   typedef struct packed {
      logic [2:0]         op;
      logic [2:0]         cam;
      logic [1:0]         row;
      logic [127:0]       row_data;   // element k at [32k+31:32k]
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [3:0]         ncam;
      logic [3:0]         thresh;
   } cmd_type;

   // Plane order: right, left, bottom, top, far, near
   function automatic logic [1:0] plane_axis(input int p);
      plane_axis = 2'(p / 2);
   endfunction

   function automatic logic plane_sub(input int p);
      plane_sub = (p == 0) || (p == 3) || (p == 4);
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
      if (v > 51'(PLANE_MAX)) begin
         sat48 = PLANE_MAX;
      end else if (v < 51'(PLANE_MIN)) begin
         sat48 = PLANE_MIN;
      end else begin
         sat48 = v[47:0];
      end
   endfunction

endpackage

// ----- hdl/mcfc_queue.sv -----
// Small synchronous queue between front, back and the result port.
module mcfc_queue
   import mcfc_pkg::*;
#(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type wdata,
   output logic     full,
   input  logic     pop,
   output item_type rdata,
   output logic     empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type           mem_ff [0:DEPTH-1];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- hdl/mcfc_front.sv -----
// Front end: configuration registers and classification of incoming beats.
module mcfc_front
   import mcfc_pkg::*;
#(
   parameter int NCAM = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wen,
   input  logic       csr_index,
   input  logic [3:0] csr_wdata,
   input  req_type    req_data,
   output cmd_type    cmd
);
   logic [3:0] cameras_ff;
   logic [3:0] thresh_ff;
   logic       cam_ok;

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cameras_ff <= '0;
         thresh_ff  <= THRESHOLD_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_CAMERAS:   cameras_ff <= csr_wdata;
            CSR_THRESHOLD: thresh_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cam_ok = ({1'b0, req_data.cam_index} < 4'(NCAM));

   // Classify: drop loads and builds aimed at missing cameras
   always_comb begin
      cmd.cam      = req_data.cam_index;
      cmd.row      = req_data.row_index;
      cmd.row_data = {req_data.elem_d, req_data.elem_c, req_data.elem_b, req_data.elem_a};
      cmd.x        = req_data.point_x;
      cmd.y        = req_data.point_y;
      cmd.z        = req_data.point_z;
      cmd.ncam     = (cameras_ff > 4'(NCAM)) ? 4'(NCAM) : cameras_ff;
      cmd.thresh   = thresh_ff;
      case (req_data.func)
         FUNC_LOAD_MV: cmd.op = cam_ok ? OP_LOAD_MV : OP_NOP;
         FUNC_LOAD_PJ: cmd.op = cam_ok ? OP_LOAD_PJ : OP_NOP;
         FUNC_BUILD:   cmd.op = cam_ok ? OP_BUILD : OP_NOP;
         FUNC_TEST:    cmd.op = OP_TEST;
         default:      cmd.op = OP_NOP;
      endcase
   end

endmodule

// ----- hdl/mcfc_back.sv -----
// Back end: matrix stores, plane build pipeline and point test pipeline.
module mcfc_back
   import mcfc_pkg::*;
#(
   parameter int NCAM = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd_rdata,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_wdata
);
   localparam int CAM_W    = (NCAM > 1) ? $clog2(NCAM) : 1;
   localparam int MV_DEPTH = NCAM * 4;
   localparam int PL_DEPTH = NCAM * 6;
   localparam int PL_AW    = $clog2(PL_DEPTH);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_BUILD  = 3'd1;
   localparam logic [2:0] ST_BDRAIN = 3'd2;
   localparam logic [2:0] ST_BWRITE = 3'd3;
   localparam logic [2:0] ST_TEST   = 3'd4;
   localparam logic [2:0] ST_TDRAIN = 3'd5;
   localparam logic [2:0] ST_RESP   = 3'd6;

   logic [127:0] mv_mem [0:MV_DEPTH-1];
   logic [127:0] pj_mem [0:MV_DEPTH-1];
   logic [191:0] pl_mem [0:PL_DEPTH-1];

   logic [2:0]   state_ff, state_in;
   cmd_type      cmd_ff;
   logic [3:0]   bcnt_ff, bcnt_in;
   logic [2:0]   wcnt_ff, wcnt_in;
   logic [2:0]   tcam_ff, tcam_in;
   logic [2:0]   tp_ff, tp_in;
   rsp_type      res_ff, res_in;

   logic [CAM_W-1:0] cam_a;
   logic [PL_AW-1:0] pl_waddr, pl_raddr;

   // build pipeline
   logic [127:0]        mv_rd_ff, pj_rd_ff;
   logic                bv1_ff, bv2_ff, bv3_ff;
   logic [3:0]          btag1_ff, btag2_ff, btag3_ff;
   logic signed [63:0]  prod_ff [0:3];
   logic signed [49:0]  acc_ff [0:3];
   logic [191:0]        pb_ff [0:5];
   logic signed [31:0]  mv_k;

   // test pipeline
   logic [191:0]        pl_rd_ff;
   logic                tv1_ff, tv2_ff, tv3_ff;
   logic [5:0]          ttag1_ff, ttag2_ff, ttag3_ff;
   logic signed [63:0]  hi_ff [0:2];
   logic signed [48:0]  lo_ff [0:2];
   logic signed [47:0]  d_ff;
   logic signed [81:0]  sum;
   logic                pos_ff;
   logic                run_ff;
   logic                flag;
   logic [7:0]          mask_ff;
   logic [3:0]          count_ff;
   logic signed [31:0]  coord [0:2];

   assign cam_a     = cmd_ff.cam[CAM_W-1:0];
   assign cmd_pop   = (state_ff == ST_IDLE) && !cmd_empty;
   assign rsp_push  = (state_ff == ST_RESP) && !rsp_full;
   assign rsp_wdata = res_ff;
   assign pl_waddr  = PL_AW'({cam_a, 2'b00}) + PL_AW'({cam_a, 1'b0}) + PL_AW'(wcnt_ff);
   assign pl_raddr  = PL_AW'({tcam_ff, 2'b00}) + PL_AW'({tcam_ff, 1'b0}) + PL_AW'(tp_ff);
   assign coord[0]  = cmd_ff.x;
   assign coord[1]  = cmd_ff.y;
   assign coord[2]  = cmd_ff.z;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      bcnt_in  = bcnt_ff;
      wcnt_in  = wcnt_ff;
      tcam_in  = tcam_ff;
      tp_in    = tp_ff;
      res_in   = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               res_in  = '0;
               bcnt_in = '0;
               tcam_in = '0;
               tp_in   = '0;
               case (cmd_rdata.op)
                  OP_BUILD: state_in = ST_BUILD;
                  OP_TEST: begin
                     if (cmd_rdata.ncam == 4'd0) begin
                        res_in.covered = (cmd_rdata.thresh == 4'd0);
                        state_in       = ST_RESP;
                     end else begin
                        state_in = ST_TEST;
                     end
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_BUILD: begin
            bcnt_in = bcnt_ff + 1'b1;
            if (bcnt_ff == 4'd15) begin
               state_in = ST_BDRAIN;
            end
         end
         ST_BDRAIN: begin
            if (!bv1_ff && !bv2_ff && !bv3_ff) begin
               wcnt_in  = '0;
               state_in = ST_BWRITE;
            end
         end
         ST_BWRITE: begin
            wcnt_in = wcnt_ff + 1'b1;
            if (wcnt_ff == 3'd5) begin
               state_in = ST_RESP;
            end
         end
         ST_TEST: begin
            if (tp_ff == 3'd5) begin
               tp_in   = '0;
               tcam_in = tcam_ff + 1'b1;
               if ({1'b0, tcam_ff} == cmd_ff.ncam - 4'd1) begin
                  state_in = ST_TDRAIN;
               end
            end else begin
               tp_in = tp_ff + 1'b1;
            end
         end
         ST_TDRAIN: begin
            if (!tv1_ff && !tv2_ff && !tv3_ff) begin
               res_in.inside_mask = mask_ff;
               res_in.cover_count = count_ff;
               res_in.covered     = (count_ff >= cmd_ff.thresh);
               state_in           = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bv1_ff   <= 1'b0;
         bv2_ff   <= 1'b0;
         bv3_ff   <= 1'b0;
         tv1_ff   <= 1'b0;
         tv2_ff   <= 1'b0;
         tv3_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         bv1_ff   <= (state_ff == ST_BUILD);
         bv2_ff   <= bv1_ff;
         bv3_ff   <= bv2_ff;
         tv1_ff   <= (state_ff == ST_TEST);
         tv2_ff   <= tv1_ff;
         tv3_ff   <= tv2_ff;
      end
   end

   always_ff @(posedge clock) begin
      bcnt_ff <= bcnt_in;
      wcnt_ff <= wcnt_in;
      tcam_ff <= tcam_in;
      tp_ff   <= tp_in;
      res_ff  <= res_in;
      if (cmd_pop) begin
         cmd_ff <= cmd_rdata;
      end
   end

   // Matrix and plane stores
   always_ff @(posedge clock) begin
      if (cmd_pop && (cmd_rdata.op == OP_LOAD_MV)) begin
         mv_mem[{cmd_rdata.cam[CAM_W-1:0], cmd_rdata.row}] <= cmd_rdata.row_data;
      end
      if (cmd_pop && (cmd_rdata.op == OP_LOAD_PJ)) begin
         pj_mem[{cmd_rdata.cam[CAM_W-1:0], cmd_rdata.row}] <= cmd_rdata.row_data;
      end
      mv_rd_ff <= mv_mem[{cam_a, bcnt_ff[3:2]}];
      pj_rd_ff <= pj_mem[{cam_a, bcnt_ff[1:0]}];
      if (state_ff == ST_BWRITE) begin
         pl_mem[pl_waddr] <= pb_ff[wcnt_ff];
      end
      pl_rd_ff <= pl_mem[pl_raddr];
   end

   // Build: one (row, k) step a cycle, four products per step
   assign mv_k = mv_rd_ff[32*btag1_ff[1:0] +: 32];

   always_ff @(posedge clock) begin
      btag1_ff <= bcnt_ff;
      btag2_ff <= btag1_ff;
      btag3_ff <= btag2_ff;
      for (int c = 0; c < 4; c++) begin
         prod_ff[c] <= mv_k * $signed(pj_rd_ff[32*c +: 32]);
         if (bv2_ff) begin
            acc_ff[c] <= ((btag2_ff[1:0] == 2'd0) ? 50'sd0 : acc_ff[c])
                         + 50'($signed(prod_ff[c][63:16]));
         end
      end
      // Extract plane coefficients of the finished clip row
      if (bv3_ff && (btag3_ff[1:0] == 2'd3)) begin
         for (int p = 0; p < 6; p++) begin
            pb_ff[p][48*btag3_ff[3:2] +: 48] <= sat48(plane_sub(p)
               ? 51'(acc_ff[3]) - 51'(acc_ff[plane_axis(p)])
               : 51'(acc_ff[3]) + 51'(acc_ff[plane_axis(p)]));
         end
      end
   end

   // Test: one plane a cycle, split products then sign check
   always_comb begin
      sum = (82'(d_ff) <<< 16);
      for (int i = 0; i < 3; i++) begin
         sum = sum + (82'(hi_ff[i]) <<< 16) + 82'(lo_ff[i]);
      end
   end

   assign flag = ((ttag3_ff[2:0] == 3'd0) ? 1'b1 : run_ff) && pos_ff;

   always_ff @(posedge clock) begin
      ttag1_ff <= {tcam_ff, tp_ff};
      ttag2_ff <= ttag1_ff;
      ttag3_ff <= ttag2_ff;
      for (int i = 0; i < 3; i++) begin
         hi_ff[i] <= $signed(pl_rd_ff[48*i+16 +: 32]) * coord[i];
         lo_ff[i] <= $signed({1'b0, pl_rd_ff[48*i +: 16]}) * coord[i];
      end
      d_ff   <= $signed(pl_rd_ff[191:144]);
      pos_ff <= !sum[81] && (sum != 82'sd0);
      if (cmd_pop) begin
         mask_ff  <= '0;
         count_ff <= '0;
      end else if (tv3_ff) begin
         run_ff <= flag;
         if ((ttag3_ff[2:0] == 3'd5) && flag) begin
            mask_ff[ttag3_ff[5:3]] <= 1'b1;
            count_ff               <= count_ff + 1'b1;
         end
      end
   end

endmodule

// ----- hdl/multi_camera_frustum_coverage_unit.sv -----
// Top level: frustum coverage unit with command and result queues.
//
// Usage: every beat on the req_ port (push while full is low) is one command:
// load a model-view or projection row of four elements, build the six
// frustum planes of a camera, or test one point against all cameras in use.
// Every command returns exactly one result beat on the rsp_ port, in order;
// loads and builds return all zeros. The result is held while rsp_empty is
// low and leaves on rsp_pop.
// A build runs sixteen multiply steps of four products, drains the
// pipeline and then writes six planes; a test checks the six planes of
// each of the N cameras in use: the back end checks one plane per cycle
// through its three split multipliers.
// Commands run one at a time in the back end; a two-entry command queue lets
// the front take the next beat meanwhile, and a two-entry result queue lets
// the back end finish while the receiver stalls. A full result queue stops
// the back end, then the command queue fills and req_full rises.
// Reset clears the queues and the registers (cameras in use 0, threshold
// 3); stores are undefined until loaded and built. Write csr_ only when idle.
module multi_camera_frustum_coverage_unit
   import mcfc_pkg::*;
#(
   parameter int NUM_CAMERAS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_data,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data,
   input  logic       csr_wen,
   input  logic       csr_index,
   input  logic [3:0] csr_wdata
);
   localparam int NCAM = (NUM_CAMERAS < MAX_CAMERAS) ? NUM_CAMERAS : MAX_CAMERAS;

   cmd_type cmd_front, cmd_head;
   logic    cmd_empty, cmd_pop;
   logic    rsp_full, rsp_push;
   rsp_type rsp_wdata;

   mcfc_front #(.NCAM(NCAM)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd_front)
   );

   mcfc_queue #(.item_type(cmd_type), .DEPTH(QUEUE_DEPTH)) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (cmd_front),
      .full  (req_full),
      .pop   (cmd_pop),
      .rdata (cmd_head),
      .empty (cmd_empty)
   );

   mcfc_back #(.NCAM(NCAM)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_rdata (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_wdata (rsp_wdata)
   );

   mcfc_queue #(.item_type(rsp_type), .DEPTH(QUEUE_DEPTH)) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wdata),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule

// ----- tb/multi_camera_frustum_coverage_unit_test.sv -----
// Testbench for the multi-camera frustum coverage unit: queued stimulus, predictor, checker.
`timescale 1ns / 1ps
module multi_camera_frustum_coverage_unit_test;
   import mcfc_pkg::*;

   localparam int CAMS = 8;
   localparam int STALL_LIMIT = 20000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   req_type    req_data = '0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wen = 1'b0;
   logic       csr_index = 1'b0;
   logic [3:0] csr_wdata = '0;

   multi_camera_frustum_coverage_unit #(.NUM_CAMERAS(CAMS)) i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Predictor state
   logic signed [31:0] mv_mem [CAMS][16];
   logic signed [31:0] pj_mem [CAMS][16];
   logic signed [47:0] plane_mem [CAMS][6][4];
   logic [3:0]         cams_used = 4'd0;
   logic [3:0]         cover_min = THRESHOLD_RESET;

   req_type pending_beats [$];
   rsp_type expected_rsp [$];
   int      error_count = 0;
   int      beats_taken = 0;
   int      results_seen = 0;
   int      idle_cycles = 0;
   bit      calm = 1'b0;
   bit      long_hold = 1'b0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got, want);
      error_count++;
   endtask

   function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
      if (v > 64'(PLANE_MAX)) return PLANE_MAX;
      if (v < 64'(PLANE_MIN)) return PLANE_MIN;
      return v[47:0];
   endfunction

   // Multiply out the clip matrix and extract the six planes
   task automatic build_frustum(input int cam);
      logic signed [63:0] clip [16];
      logic signed [63:0] prod, w, e;
      int ax;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++) begin
            clip[4*r+c] = 0;
            for (int k = 0; k < 4; k++) begin
               prod = 64'(mv_mem[cam][4*r+k]) * 64'(pj_mem[cam][4*k+c]);
               clip[4*r+c] += prod >>> 16;
            end
         end
      for (int p = 0; p < 6; p++)
         for (int j = 0; j < 4; j++) begin
            ax = p / 2;
            w = clip[4*j+3];
            e = clip[4*j+ax];
            plane_mem[cam][p][j] = (p == 0 || p == 3 || p == 4) ?
                                   clamp48(w - e) : clamp48(w + e);
         end
   endtask

   function automatic bit camera_sees(input int cam, input logic signed [31:0] x,
                                      input logic signed [31:0] y,
                                      input logic signed [31:0] z);
      logic signed [95:0] s;
      for (int p = 0; p < 6; p++) begin
         s = 96'(plane_mem[cam][p][0]) * 96'(x) + 96'(plane_mem[cam][p][1]) * 96'(y)
           + 96'(plane_mem[cam][p][2]) * 96'(z) + (96'(plane_mem[cam][p][3]) <<< 16);
         if (s <= 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Apply one accepted beat and queue its expected result
   task automatic predict_coverage(input req_type b);
      rsp_type r;
      int n;
      r = '0;
      case (b.func)
         FUNC_LOAD_MV: for (int i = 0; i < 4; i++)
            mv_mem[b.cam_index][4*b.row_index+i] =
               (i == 0) ? b.elem_a : (i == 1) ? b.elem_b : (i == 2) ? b.elem_c : b.elem_d;
         FUNC_LOAD_PJ: for (int i = 0; i < 4; i++)
            pj_mem[b.cam_index][4*b.row_index+i] =
               (i == 0) ? b.elem_a : (i == 1) ? b.elem_b : (i == 2) ? b.elem_c : b.elem_d;
         FUNC_BUILD: build_frustum(b.cam_index);
         default: begin
            n = (cams_used > CAMS) ? CAMS : cams_used;
            for (int k = 0; k < n; k++)
               if (camera_sees(k, b.point_x, b.point_y, b.point_z)) begin
                  r.inside_mask[k] = 1'b1;
                  r.cover_count++;
               end
            r.covered = (r.cover_count >= cover_min);
         end
      endcase
      expected_rsp.push_back(r);
   endtask

   // Driver: offer queued beats with random gaps
   int send_gap = 0;
   bit send_hold = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_coverage(req_data);
            beats_taken++;
         end
         if (req_push && req_full) begin
            // hold the offered beat
         end else if (send_hold || pending_beats.size() == 0) begin
            req_push <= 1'b0;
         end else if (send_gap > 0) begin
            send_gap--;
            req_push <= 1'b0;
         end else begin
            req_data <= pending_beats.pop_front();
            req_push <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
         end
      end
   end

   // Monitor: pop with random stalls and compare
   int recv_gap = 0;
   always @(posedge clock) begin
      rsp_type w;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected result", rsp_data, 0);
            end else begin
               w = expected_rsp.pop_front();
               if (rsp_data.inside_mask !== w.inside_mask)
                  report_mismatch("inside_mask", rsp_data.inside_mask, w.inside_mask);
               if (rsp_data.cover_count !== w.cover_count)
                  report_mismatch("cover_count", rsp_data.cover_count, w.cover_count);
               if (rsp_data.covered !== w.covered)
                  report_mismatch("covered", rsp_data.covered, w.covered);
            end
         end
         if (long_hold) begin
            rsp_pop <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 9);
         end
      end
   end

   // Watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (!long_hold && !reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_LIMIT) begin
            $display("multi_camera_frustum_coverage_unit_test: done, errors");
            $finish;
         end
      end
   end

   function automatic logic [31:0] rand_elem();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom;
         default: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      endcase
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom;
         3: return 32'd0;
         default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      endcase
   endfunction

   function automatic req_type make_beat(input logic [1:0] f, input int cam, input int row);
      req_type b;
      b.func = f;
      b.cam_index = 3'(cam);
      b.row_index = 2'(row);
      b.elem_a = rand_elem(); b.elem_b = rand_elem();
      b.elem_c = rand_elem(); b.elem_d = rand_elem();
      b.point_x = rand_coord(); b.point_y = rand_coord(); b.point_z = rand_coord();
      return b;
   endfunction

   task automatic queue_test();
      pending_beats.push_back(make_beat(FUNC_TEST, $urandom_range(0, 7), $urandom_range(0, 3)));
   endtask

   // Load, build a perspective camera: identity-ish model-view, projection; random if wild
   task automatic queue_camera(input int cam, input bit wild);
      req_type b;
      for (int r = 0; r < 4; r++) begin
         b = make_beat(FUNC_LOAD_MV, cam, r);
         if (!wild) begin
            b.elem_a = (r == 0) ? 32'h0100_0000 : $signed($urandom_range(0, 'h40_0000)) - 'h20_0000;
            b.elem_b = (r == 1) ? 32'h0100_0000 : $signed($urandom_range(0, 'h40_0000)) - 'h20_0000;
            b.elem_c = (r == 2) ? 32'h0100_0000 : $signed($urandom_range(0, 'h40_0000)) - 'h20_0000;
            b.elem_d = (r == 3) ? 32'h0100_0000 : 32'h0;
         end
         pending_beats.push_back(b);
      end
      for (int r = 0; r < 4; r++) begin
         b = make_beat(FUNC_LOAD_PJ, cam, r);
         if (!wild) begin
            b.elem_a = (r == 0) ? 32'h0100_0000 + $urandom_range(0, 'h80_0000) : 32'h0;
            b.elem_b = (r == 1) ? 32'h0100_0000 + $urandom_range(0, 'h80_0000) : 32'h0;
            b.elem_c = (r == 2) ? -32'sh0100_0000 : (r == 3) ? -32'sh0020_0000 : 32'h0;
            b.elem_d = (r == 2) ? -32'sh0100_0000 : 32'h0;
         end
         pending_beats.push_back(b);
      end
      pending_beats.push_back(make_beat(FUNC_BUILD, cam, $urandom_range(0, 3)));
   endtask

   task automatic wait_drained();
      while (pending_beats.size() != 0 || req_push || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [3:0] v);
      @(posedge clock);
      csr_wen <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == CSR_CAMERAS) cams_used = v; else cover_min = v;
   endtask

   initial begin
      req_type b;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: every camera built, tests against extremes
      write_reg(CSR_CAMERAS, 4'd8);
      write_reg(CSR_THRESHOLD, 4'd0);
      for (int c = 0; c < CAMS; c++) queue_camera(c, c == 7);
      b = make_beat(FUNC_TEST, 0, 0);
      b.point_x = 0; b.point_y = 0; b.point_z = -32'sh0002_0000;
      pending_beats.push_back(b);
      b.point_x = 32'h7FFF_FFFF; b.point_y = 32'h8000_0000; b.point_z = 32'h8000_0000;
      pending_beats.push_back(b);
      b.point_x = 32'h8000_0000; b.point_y = 32'h7FFF_FFFF; b.point_z = 32'h7FFF_FFFF;
      pending_beats.push_back(b);
      for (int i = 0; i < 5; i++) queue_test();
      wait_drained();

      // Random phases over several register settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin write_reg(CSR_CAMERAS, 4'd15); write_reg(CSR_THRESHOLD, 4'd15); end
            1: begin write_reg(CSR_CAMERAS, 4'd0);  write_reg(CSR_THRESHOLD, 4'd0);  end
            2: begin write_reg(CSR_CAMERAS, 4'd8);  write_reg(CSR_THRESHOLD, 4'd8);  end
            3: begin write_reg(CSR_CAMERAS, 4'd9);  write_reg(CSR_THRESHOLD, 4'd9);  end
            default: begin
               write_reg(CSR_CAMERAS, 4'($urandom_range(1, 8)));
               write_reg(CSR_THRESHOLD, 4'($urandom_range(0, 4)));
            end
         endcase
         calm = (ph == 7);
         for (int i = 0; i < 110; i++) begin
            case ($urandom_range(0, 9))
               0: queue_camera($urandom_range(0, 7), $urandom_range(0, 3) == 0);
               1: pending_beats.push_back(make_beat(2'($urandom_range(0, 1)),
                     $urandom_range(0, 7), $urandom_range(0, 3)));
               default: queue_test();
            endcase
            // partial loads break a camera until it is rebuilt; on every ninth pass rebuild at once
            if (pending_beats.size() > 0 && pending_beats[$].func != FUNC_TEST &&
                pending_beats[$].func != FUNC_BUILD && i % 9 == 1)
               pending_beats.push_back(make_beat(FUNC_BUILD,
                  pending_beats[$].cam_index, 0));
         end
         if (ph == 2) begin
            // hold the receiver so the block backs up onto its input
            long_hold = 1'b1;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         if (ph == 4) begin
            // pause the sender until every result is in
            send_hold = 1'b1;
            while (expected_rsp.size() != 0 || req_push) @(posedge clock);
            send_hold = 1'b0;
         end
         wait_drained();
      end

      if (error_count == 0)
         $display("multi_camera_frustum_coverage_unit_test: done, clean");
      else
         $display("multi_camera_frustum_coverage_unit_test: done, errors");
      $finish;
   end

endmodule
